// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Common concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/tkst_pkg.sv =====
// ----------------------------------------------------------------------------
// tkst_pkg
// Types, widths and codes shared by the ranked score table modules.
// ----------------------------------------------------------------------------
package tkst_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int ID_W        = 16;
	localparam int SCORE_W     = 16;
	localparam int IDX_W       = 6;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_RD_EVAL,
		ST_INS_LOAD,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RA_ITEM,
		RA_LAST,
		RA_PRE_LAST,
		RA_WALK
	} raddr_sel_t;

	typedef struct packed {
		logic signed [ID_W-1:0] id;
		logic [SCORE_W-1:0]     score;
	} entry_t;

	typedef struct packed {
		logic       load_item;
		raddr_sel_t raddr_sel;
		logic       walk_init;
		logic       walk_step;
		logic       read_eval;
		logic       ins_result;
		logic       push;
	} dp_cmd_t;

	typedef struct packed {
		logic is_read;
		logic walk_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/top_k_score_table_top.sv =====
// ----------------------------------------------------------------------------
// top_k_score_table_top
// Ranked table of ENTRIES (id, score) pairs kept in descending score order,
// score zero marking an empty slot, all slots empty after reset. An insert
// takes the first empty slot or, in a full table, replaces the first lowest
// entry, and lands after entries of equal score; a read returns the entry at
// a rank if its score is nonzero and its id is not negative. One request is
// in work at a time. A read passes the issue and evaluate states; an insert
// walks back from the last slot, visiting 1 to ENTRIES slots, one per
// cycle, with one read and at most one write of the table memory per cycle.
// ----------------------------------------------------------------------------
module top_k_score_table_top #(
	parameter int ENTRIES = tkst_pkg::ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic signed [tkst_pkg::ID_W-1:0]    new_id,
	input  logic        [tkst_pkg::SCORE_W-1:0] new_score,
	input  logic        [tkst_pkg::IDX_W-1:0]   read_index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                found,
	output logic signed [tkst_pkg::ID_W-1:0]    entry_id,
	output logic        [tkst_pkg::SCORE_W-1:0] entry_score
);
	import tkst_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t stat;

	tkst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.dcmd     (dcmd)
	);

	tkst_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.new_id      (new_id),
		.new_score   (new_score),
		.read_index  (read_index),
		.dcmd        (dcmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.entry_id    (entry_id),
		.entry_score (entry_score)
	);

endmodule

// ===== rtl/tkst_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkst_ctrl
// Sequencer: accepts a request, runs the read or the insert walk, hands the
// result to the output register.
// ----------------------------------------------------------------------------
module tkst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tkst_pkg::dp_stat_t stat,
	output tkst_pkg::dp_cmd_t  dcmd
);
	import tkst_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		in_stall       = 1'b1;
		dcmd           = '0;
		dcmd.raddr_sel = RA_ITEM;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					dcmd.load_item = 1'b1;
					state_d        = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (stat.is_read) begin
					dcmd.raddr_sel = RA_ITEM;
					state_d        = ST_RD_EVAL;
				end else begin
					dcmd.raddr_sel = RA_LAST;
					state_d        = ST_INS_LOAD;
				end
			end
			ST_RD_EVAL: begin
				dcmd.read_eval = 1'b1;
				state_d        = ST_DONE;
			end
			ST_INS_LOAD: begin
				dcmd.walk_init = 1'b1;
				dcmd.raddr_sel = RA_PRE_LAST;
				state_d        = ST_WALK;
			end
			ST_WALK: begin
				dcmd.walk_step = 1'b1;
				dcmd.raddr_sel = RA_WALK;
				if (stat.walk_done) begin
					dcmd.ins_result = 1'b1;
					state_d         = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					dcmd.push = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/tkst_dp.sv =====
// ----------------------------------------------------------------------------
// tkst_dp
// Table memory, request registers, insertion walk and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tkst_dp #(
	parameter int ENTRIES = tkst_pkg::ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd,
	input  logic signed [tkst_pkg::ID_W-1:0]    new_id,
	input  logic        [tkst_pkg::SCORE_W-1:0] new_score,
	input  logic        [tkst_pkg::IDX_W-1:0]   read_index,
	input  tkst_pkg::dp_cmd_t                   dcmd,
	output tkst_pkg::dp_stat_t                  stat,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                found,
	output logic signed [tkst_pkg::ID_W-1:0]    entry_id,
	output logic        [tkst_pkg::SCORE_W-1:0] entry_score
);
	import tkst_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam logic [AW-1:0] LAST     = AW'(ENTRIES - 1);
	localparam logic [AW-1:0] PRE_LAST = AW'(ENTRIES - 2);

	// request
	cmd_t          item_cmd_q;
	entry_t        item_q;
	logic [AW-1:0] item_idx_q;
	logic          item_inr_q;
	logic [XW-1:0] idx_ext;

	// table
	entry_t             mem_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	entry_t             rdata_q;
	logic               rvalid_q;
	entry_t             rd;
	logic [AW-1:0]      raddr;
	logic               wen;
	logic [AW-1:0]      waddr;
	entry_t             wdata;

	// walk
	logic [AW-1:0]      j_q;
	logic [SCORE_W-1:0] v_q;
	entry_t             cur_q;
	entry_t             carry_q;
	logic               case_b;
	logic               j_nz;
	logic               run;
	logic               cont;

	// result
	logic   res_found_q;
	entry_t res_q;
	logic   out_valid_q;
	logic   found_q;
	entry_t out_q;
	logic   hit;

	assign idx_ext = XW'(read_index);

	always_ff @(posedge clk) begin
		if (dcmd.load_item) begin
			item_cmd_q   <= cmd_t'(cmd);
			item_q.id    <= new_id;
			item_q.score <= new_score;
			item_idx_q   <= idx_ext[AW-1:0];
			item_inr_q   <= (idx_ext < XW'(ENTRIES));
		end
	end

	always_comb begin
		unique case (dcmd.raddr_sel)
			RA_ITEM:     raddr = item_idx_q;
			RA_LAST:     raddr = LAST;
			RA_PRE_LAST: raddr = PRE_LAST;
			RA_WALK:     raddr = j_q - AW'(2);
			default:     raddr = item_idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q  <= mem_q[raddr];
		rvalid_q <= valid_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wen) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// slot never written reads as empty
	assign rd = rvalid_q ? rdata_q : '0;

	assign case_b = item_q.score < v_q;
	assign j_nz   = j_q != '0;
	assign run    = j_nz && (rd.score == v_q);

	always_comb begin
		wen   = 1'b0;
		waddr = j_q;
		wdata = item_q;
		cont  = 1'b0;
		if (dcmd.walk_step) begin
			priority if (case_b) begin
				// new pair ranks last: rotate the lowest run up by one
				wen   = 1'b1;
				wdata = carry_q;
				cont  = run;
			end else if (run) begin
				cont = 1'b1;
			end else if (j_nz && (rd.score < item_q.score)) begin
				wen   = 1'b1;
				wdata = rd;
				cont  = 1'b1;
			end else begin
				wen   = 1'b1;
				wdata = item_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.walk_init) begin
			j_q     <= LAST;
			v_q     <= rd.score;
			cur_q   <= rd;
			carry_q <= item_q;
		end else if (dcmd.walk_step && cont) begin
			j_q <= j_q - AW'(1);
			if (case_b) begin
				carry_q <= cur_q;
				cur_q   <= rd;
			end
		end
	end

	assign hit = item_inr_q && (rd.score != '0) && !rd.id[ID_W-1];

	always_ff @(posedge clk) begin
		if (dcmd.read_eval) begin
			res_found_q <= hit;
			res_q       <= hit ? rd : '0;
		end else if (dcmd.ins_result) begin
			res_found_q <= 1'b1;
			res_q       <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dcmd.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.push) begin
			found_q <= res_found_q;
			out_q   <= res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign entry_id    = out_q.id;
	assign entry_score = out_q.score;

	assign stat.is_read   = item_cmd_q == CMD_READ;
	assign stat.walk_done = !cont;
	assign stat.out_free  = !out_valid_q || !out_stall;

	`ASSERT_IMP(a_push_free, dcmd.push, (!out_valid_q || !out_stall))
	`ASSERT_IMP(a_walk_range, dcmd.walk_step, (j_q <= LAST))
	`ASSERT_NXT(a_walk_dec, (dcmd.walk_step && cont), (j_q == $past(j_q) - AW'(1)))

endmodule

// ===== test/tb_top_k_score_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_score_table_top
// Self-checking bench for the ranked score table. A scoreboard class keeps a
// shadow copy of the sorted table and predicts each response. Stimulus is a
// short directed pass followed by random insert/read traffic under several
// sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
typedef struct packed {
	logic                             found;
	logic signed [tkst_pkg::ID_W-1:0] id;
	logic [tkst_pkg::SCORE_W-1:0]     score;
} rank_resp_t;

class rank_scoreboard;
	logic [tkst_pkg::SCORE_W-1:0] score_tbl [tkst_pkg::ENTRIES_DEF];
	logic [tkst_pkg::ID_W-1:0]    id_tbl [tkst_pkg::ENTRIES_DEF];
	rank_resp_t                   resp_q [$];
	int errors;
	int n_insert;
	int n_read;
	int n_hit;
	int n_replace;
	int n_zero_ins;

	function new();
		for (int i = 0; i < tkst_pkg::ENTRIES_DEF; i++) begin
			score_tbl[i] = '0;
			id_tbl[i]    = '0;
		end
		errors = 0;
		n_insert = 0;
		n_read = 0;
		n_hit = 0;
		n_replace = 0;
		n_zero_ins = 0;
	endfunction

	// stable insertion sort, descending score
	function void resort();
		logic [tkst_pkg::SCORE_W-1:0] ks;
		logic [tkst_pkg::ID_W-1:0]    kid;
		int j;
		for (int i = 1; i < tkst_pkg::ENTRIES_DEF; i++) begin
			ks  = score_tbl[i];
			kid = id_tbl[i];
			j = i;
			while (j > 0 && score_tbl[j-1] < ks) begin
				score_tbl[j] = score_tbl[j-1];
				id_tbl[j]    = id_tbl[j-1];
				j--;
			end
			score_tbl[j] = ks;
			id_tbl[j]    = kid;
		end
	endfunction

	function void insert_pair(logic [tkst_pkg::ID_W-1:0] id,
			logic [tkst_pkg::SCORE_W-1:0] sc);
		int low_pos;
		logic [tkst_pkg::SCORE_W-1:0] low_sc;
		bit have_low;
		low_pos  = 0;
		low_sc   = '0;
		have_low = 0;
		for (int i = 0; i < tkst_pkg::ENTRIES_DEF; i++) begin
			if (score_tbl[i] == 0) begin
				score_tbl[i] = sc;
				id_tbl[i]    = id;
				resort();
				return;
			end
			if (!have_low || score_tbl[i] < low_sc) begin
				have_low = 1;
				low_pos  = i;
				low_sc   = score_tbl[i];
			end
		end
		n_replace++;
		score_tbl[low_pos] = sc;
		id_tbl[low_pos]    = id;
		resort();
	endfunction

	function void note_request(tkst_pkg::cmd_t c, logic [tkst_pkg::ID_W-1:0] id,
			logic [tkst_pkg::SCORE_W-1:0] sc, logic [tkst_pkg::IDX_W-1:0] idx);
		rank_resp_t r;
		r = '0;
		if (c == tkst_pkg::CMD_INSERT) begin
			n_insert++;
			if (sc == 0)
				n_zero_ins++;
			insert_pair(id, sc);
			r.found = 1'b1;
		end else begin
			n_read++;
			if (idx < tkst_pkg::ENTRIES_DEF && score_tbl[idx] != 0 &&
					!id_tbl[idx][tkst_pkg::ID_W-1]) begin
				n_hit++;
				r.found = 1'b1;
				r.id    = id_tbl[idx];
				r.score = score_tbl[idx];
			end
		end
		resp_q.push_back(r);
	endfunction

	function void check_result(logic f, logic signed [tkst_pkg::ID_W-1:0] id,
			logic [tkst_pkg::SCORE_W-1:0] sc);
		rank_resp_t e;
		if (resp_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected response, expected none actual found=%0d id=%0d score=%0d",
				$time, f, id, sc);
			return;
		end
		e = resp_q.pop_front();
		if (f !== e.found) begin
			errors++;
			$display("%0t: found mismatch, expected %0d actual %0d", $time, e.found, f);
		end
		if (id !== e.id) begin
			errors++;
			$display("%0t: entry_id mismatch, expected %0d actual %0d", $time, e.id, id);
		end
		if (sc !== e.score) begin
			errors++;
			$display("%0t: entry_score mismatch, expected %0d actual %0d", $time, e.score, sc);
		end
	endfunction

	function int pending();
		return resp_q.size();
	endfunction
endclass

module tb_top_k_score_table_top;
	import tkst_pkg::*;

	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int ITEMS_PER_PHASE = 483;
	localparam int LONG_HOLD       = 400;
	localparam int TAIL_CYCLES     = 150;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic                   cmd;
	logic signed [ID_W-1:0] new_id;
	logic [SCORE_W-1:0]     new_score;
	logic [IDX_W-1:0]       read_index;
	logic                   out_valid;
	logic                   out_stall;
	logic                   found;
	logic signed [ID_W-1:0] entry_id;
	logic [SCORE_W-1:0]     entry_score;

	rank_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;

	top_k_score_table_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.new_id     (new_id),
		.new_score  (new_score),
		.read_index (read_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.entry_id   (entry_id),
		.entry_score(entry_score)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// response side
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result(found, entry_id, entry_score);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d responses outstanding", $time, sb.pending());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_request(cmd_t c, logic [ID_W-1:0] id, logic [SCORE_W-1:0] sc,
			logic [IDX_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		new_id     <= id;
		new_score  <= sc;
		read_index <= idx;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(c, id, sc, idx);
	endtask

	task automatic send_random();
		cmd_t c;
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] sc;
		logic [IDX_W-1:0]   idx;
		c  = ($urandom_range(99) < 55) ? CMD_INSERT : CMD_READ;
		id = ID_W'($urandom);
		case ($urandom_range(9))
			0:       sc = '0;
			1, 2, 3: sc = SCORE_W'($urandom_range(4, 1));
			4:       sc = '1;
			default: sc = SCORE_W'($urandom);
		endcase
		idx = IDX_W'($urandom);
		send_request(c, id, sc, idx);
	endtask

	task automatic wait_drain();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 0;
		arst_n      = 1'b0;
		in_valid   <= 1'b0;
		cmd        <= CMD_INSERT;
		new_id     <= '0;
		new_score  <= '0;
		read_index <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty reads, extremes, negative id, zero score, ties
		send_request(CMD_READ,   16'h0000, 16'h0000, 6'd0);
		send_request(CMD_READ,   16'hFFFF, 16'hFFFF, 6'd63);
		send_request(CMD_INSERT, 16'h7FFF, 16'hFFFF, 6'd0);
		send_request(CMD_INSERT, 16'h8000, 16'h0001, 6'd63);
		send_request(CMD_INSERT, 16'hFFFF, 16'h0000, 6'd0);
		send_request(CMD_INSERT, 16'h0007, 16'h0100, 6'd0);
		send_request(CMD_INSERT, 16'h0008, 16'h0100, 6'd0);
		send_request(CMD_INSERT, 16'h0000, 16'h0001, 6'd0);
		for (int i = 0; i < 6; i++)
			send_request(CMD_READ, 16'h0000, 16'h0000, i[IDX_W-1:0]);
		send_request(CMD_READ,   16'h0000, 16'h0000, 6'd63);
		send_request(CMD_INSERT, 16'h1234, 16'h8000, 6'd0);
		send_request(CMD_READ,   16'h0000, 16'h0000, 6'd0);
		send_request(CMD_READ,   16'h0000, 16'h0000, 6'd1);
		in_valid <= 1'b0;
		wait_drain();

		// random phases: none, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 0 && n == 120)
					hold_request = LONG_HOLD;
				send_random();
			end
			in_valid <= 1'b0;
			wait_drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.errors++;
			$display("%0t: %0d responses missing, expected %0d actual 0",
				$time, sb.pending(), sb.pending());
		end
		$display("Covered %0d inserts (%0d zero score, %0d into a full table), %0d reads (%0d hits)",
			sb.n_insert, sb.n_zero_ins, sb.n_replace, sb.n_read, sb.n_hit);
		$display("Idle mixes: none, sender 61%%, receiver 61%%, both 16%%, plus one long hold-off");
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
